@@ hw/rtl/fpsw_pkg.sv @@
// Shared widths and types of the fractional-period square-wave generator.
package fpsw_pkg;

  localparam int unsigned FreqW   = 25;
  localparam int unsigned PeriodW = 26;

  localparam logic [PeriodW-1:0] PeriodMax = '1;

  typedef logic [FreqW-1:0]   freq_t;
  typedef logic [PeriodW-1:0] period_t;

endpackage

@@ hw/rtl/fpsw_if.sv @@
// Handshake channels of the fractional-period square-wave generator.
interface fpsw_tick_if;
  logic valid;
  logic ready;
  logic advance;
  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface fpsw_res_if;
  logic valid;
  logic ready;
  logic wave_out;
  logic period_end;
  modport source (output valid, output wave_out, output period_end, input ready);
  modport sink   (input valid, input wave_out, input period_end, output ready);
endinterface

interface fpsw_cfg_if;
  logic                valid;
  logic                ready;
  fpsw_pkg::freq_t     out_freq;
  modport source (output valid, output out_freq, input ready);
  modport sink   (input valid, input out_freq, output ready);
endinterface

@@ hw/rtl/fractional_period_square_wave_top.sv @@
// Fractional-period square-wave generator: period counter, start-up divider, result register.
//
//   channel  | dir | payload             | beat
//   ---------+-----+---------------------+-----------------------------
//   tick_i   | in  | advance             | one timer tick (or hold)
//   res_o    | out | wave_out,period_end | one result per tick beat
//   cfg_i    | in  | out_freq            | frequency write, starts/stops
//
// One tick beat per cycle unless the divider is busy or the result side stalls;
// the counter logic sits between the state registers and the result register,
// which is refilled while its beat is taken. A nonzero frequency write runs a
// restoring divider, one quotient bit per cycle, with tick_i and cfg_i not ready
// until it finishes. A zero write stops the block at once. Reset leaves it stopped.
module fractional_period_square_wave_top #(
  parameter int unsigned CLOCK_HZ = 48000000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpsw_tick_if.sink   tick_i,
  fpsw_res_if.source  res_o,
  fpsw_cfg_if.sink    cfg_i
);

  localparam int unsigned FreqW   = fpsw_pkg::FreqW;
  localparam int unsigned PeriodW = fpsw_pkg::PeriodW;
  localparam int unsigned DivW    = $clog2(CLOCK_HZ + 1);
  localparam int unsigned QuotW   = (DivW > PeriodW) ? DivW : PeriodW;
  localparam int unsigned CntW    = $clog2(DivW + 1);

  // generator state
  fpsw_pkg::period_t tick_q, tick_d;
  fpsw_pkg::period_t base_q, base_d;
  fpsw_pkg::freq_t   rem_q, rem_d;
  fpsw_pkg::freq_t   frac_q, frac_d;
  fpsw_pkg::freq_t   freq_q, freq_d;
  logic              ext_q, ext_d;
  logic              run_q, run_d;

  // divider
  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DivW-1:0]   dvd_q, dvd_d;
  logic [QuotW-1:0]  quot_q, quot_d;
  fpsw_pkg::freq_t   part_q, part_d;

  // result register
  logic out_vld_q, out_vld_d;
  logic wave_q, wave_d;
  logic pend_q, pend_d;

  logic             in_fire, cfg_fire;
  logic [FreqW:0]   part_sh;
  logic             qbit;
  fpsw_pkg::freq_t  part_nxt;
  logic [QuotW-1:0] quot_nxt;
  logic [PeriodW:0] len_c;
  logic [PeriodW:0] tick_inc;
  logic             wave_c, pend_c;
  fpsw_pkg::freq_t  frac_nxt;

  assign tick_i.ready = !busy_q && (!out_vld_q || res_o.ready);
  assign cfg_i.ready  = !busy_q;
  assign in_fire      = tick_i.valid && tick_i.ready;
  assign cfg_fire     = cfg_i.valid && cfg_i.ready;

  assign res_o.valid      = out_vld_q;
  assign res_o.wave_out   = wave_q;
  assign res_o.period_end = pend_q;

  // one restoring-division step
  always_comb begin
    part_sh  = {part_q, dvd_q[DivW-1]};
    qbit     = (part_sh >= {1'b0, freq_q});
    part_nxt = qbit ? FreqW'(part_sh - {1'b0, freq_q}) : part_sh[FreqW-1:0];
    quot_nxt = {quot_q[QuotW-2:0], qbit};
  end

  // period arithmetic for one tick
  always_comb begin
    len_c = {1'b0, base_q} + (PeriodW+1)'(ext_q);
    if (len_c == '0) begin
      len_c = (PeriodW+1)'(1);
    end
    tick_inc = {1'b0, tick_q} + (PeriodW+1)'(1);
    wave_c   = run_q && (tick_q < (base_q >> 1));
    pend_c   = run_q && tick_i.advance && (tick_inc >= len_c);
    frac_nxt = (frac_q <= FreqW'(1)) ? freq_q : FreqW'(frac_q - FreqW'(1));
  end

  always_comb begin
    tick_d    = tick_q;
    base_d    = base_q;
    rem_d     = rem_q;
    frac_d    = frac_q;
    freq_d    = freq_q;
    ext_d     = ext_q;
    run_d     = run_q;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    quot_d    = quot_q;
    part_d    = part_q;
    out_vld_d = out_vld_q;
    wave_d    = wave_q;
    pend_d    = pend_q;

    if (res_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (in_fire) begin
      out_vld_d = 1'b1;
      wave_d    = wave_c;
      pend_d    = pend_c;
      if (run_q && tick_i.advance) begin
        if (pend_c) begin
          tick_d = '0;
          frac_d = frac_nxt;
          ext_d  = (frac_nxt <= rem_q);
        end else begin
          tick_d = tick_inc[PeriodW-1:0];
        end
      end
    end

    if (busy_q) begin
      dvd_d  = dvd_q << 1;
      quot_d = quot_nxt;
      part_d = part_nxt;
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        rem_d  = part_nxt;
        // saturate an oversized quotient
        if (quot_nxt > QuotW'(fpsw_pkg::PeriodMax)) begin
          base_d = fpsw_pkg::PeriodMax;
        end else begin
          base_d = quot_nxt[PeriodW-1:0];
        end
      end
    end

    if (cfg_fire) begin
      freq_d = cfg_i.out_freq;
      tick_d = '0;
      if (cfg_i.out_freq == '0) begin
        run_d = 1'b0;
      end else begin
        run_d  = 1'b1;
        frac_d = cfg_i.out_freq;
        ext_d  = 1'b0;
        busy_d = 1'b1;
        cnt_d  = CntW'(DivW);
        dvd_d  = DivW'(CLOCK_HZ);
        quot_d = '0;
        part_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      base_q    <= '0;
      rem_q     <= '0;
      frac_q    <= '0;
      freq_q    <= '0;
      ext_q     <= 1'b0;
      run_q     <= 1'b0;
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      base_q    <= base_d;
      rem_q     <= rem_d;
      frac_q    <= frac_d;
      freq_q    <= freq_d;
      ext_q     <= ext_d;
      run_q     <= run_d;
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    part_q <= part_d;
    wave_q <= wave_d;
    pend_q <= pend_d;
  end

`ifndef SYNTH
  a_no_tick_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !tick_i.ready)
    else $error("tick taken during division");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CntW'(1) && !cfg_fire) |=> !busy_q)
    else $error("divider did not finish");

  a_count_in_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !busy_q) |-> ({1'b0, tick_q} < len_c))
    else $error("tick count beyond period length");

  a_end_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pend_c && !cfg_fire) |=> (tick_q == '0 && out_vld_q && pend_q))
    else $error("period end did not restart the count");
`endif

endmodule

@@ dv/fpsw_wave_checker.sv @@
// Checker for the square-wave generator: predicts each result beat and compares it.
module fpsw_wave_checker #(
  parameter int unsigned CLOCK_HZ = 48000000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpsw_tick_if        tick_i,
  fpsw_res_if         res_i,
  fpsw_cfg_if         cfg_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic wave;
    logic period_end;
  } wave_beat_t;

  wave_beat_t wave_expect_q[$];
  wave_beat_t beat;
  wave_beat_t want;

  fpsw_pkg::freq_t   freq_q;
  fpsw_pkg::period_t tick_cnt_q;
  fpsw_pkg::period_t base_period_q;
  fpsw_pkg::freq_t   rem_ticks_q;
  fpsw_pkg::freq_t   frac_cnt_q;
  logic              stretch_q;
  logic              running_q;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors_o++;
  endtask

  task automatic load_freq(input fpsw_pkg::freq_t f);
    longint unsigned quo;
    freq_q = f;
    if (f == '0) begin
      running_q  = 1'b0;
      tick_cnt_q = '0;
    end else begin
      quo = 64'(CLOCK_HZ) / 64'(f);
      if (quo > 64'(fpsw_pkg::PeriodMax)) quo = 64'(fpsw_pkg::PeriodMax);
      base_period_q = fpsw_pkg::period_t'(quo);
      rem_ticks_q   = fpsw_pkg::freq_t'(64'(CLOCK_HZ) % 64'(f));
      frac_cnt_q    = f;
      stretch_q     = 1'b0;
      tick_cnt_q    = '0;
      running_q     = 1'b1;
    end
  endtask

  task automatic step_wave(input logic adv, output wave_beat_t res);
    logic [fpsw_pkg::PeriodW:0] len;
    logic [fpsw_pkg::PeriodW:0] nxt;
    res = '0;
    if (running_q) begin
      res.wave = (tick_cnt_q < (base_period_q >> 1));
      if (adv) begin
        len = {1'b0, base_period_q} + {{fpsw_pkg::PeriodW{1'b0}}, stretch_q};
        // a zero-length period still takes one tick
        if (len == '0) len = (fpsw_pkg::PeriodW+1)'(1);
        nxt = {1'b0, tick_cnt_q} + 1'b1;
        if (nxt >= len) begin
          tick_cnt_q     = '0;
          res.period_end = 1'b1;
          if (frac_cnt_q <= 1) frac_cnt_q = freq_q;
          else frac_cnt_q = frac_cnt_q - 1'b1;
          stretch_q = (frac_cnt_q <= rem_ticks_q);
        end else begin
          tick_cnt_q = nxt[fpsw_pkg::PeriodW-1:0];
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_expect_q.delete();
      errors_o      = 0;
      outstanding_o = 0;
      freq_q        = '0;
      tick_cnt_q    = '0;
      base_period_q = '0;
      rem_ticks_q   = '0;
      frac_cnt_q    = '0;
      stretch_q     = 1'b0;
      running_q     = 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) load_freq(cfg_i.out_freq);
      if (tick_i.valid && tick_i.ready) begin
        step_wave(tick_i.advance, beat);
        wave_expect_q.push_back(beat);
      end
      if (res_i.valid && res_i.ready) begin
        if (wave_expect_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = wave_expect_q.pop_front();
          if (res_i.wave_out !== want.wave)
            report_mismatch($sformatf("wave_out %b, expected %b",
                                      res_i.wave_out, want.wave));
          if (res_i.period_end !== want.period_end)
            report_mismatch($sformatf("period_end %b, expected %b",
                                      res_i.period_end, want.period_end));
        end
      end
      outstanding_o = wave_expect_q.size();
    end
  end

endmodule

@@ dv/tb_fractional_period_square_wave_top.sv @@
// Testbench top for the square-wave generator: clock, reset, stimulus and verdict.
module tb_fractional_period_square_wave_top;

  localparam int unsigned ClockHz   = 48000000;
  localparam int unsigned FreqHi    = 24000000;
  localparam int unsigned RandItems = 1900;
  localparam int unsigned LongHold  = 160;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_req;
  logic        hold_done;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_cnt = 0;

  fpsw_tick_if tick_if ();
  fpsw_res_if  res_if ();
  fpsw_cfg_if  cfg_if ();

  fractional_period_square_wave_top #(
    .CLOCK_HZ(ClockHz)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .tick_i(tick_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  fpsw_wave_checker #(
    .CLOCK_HZ(ClockHz)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .tick_i       (tick_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .errors_o     (mismatches),
    .outstanding_o(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // no idling on either side inside this window
  function automatic logic quiet_window();
    return cycle_cnt >= 900 && cycle_cnt < 1700;
  endfunction

  // frequency whose base period is b and whose periods start to stretch after a few periods
  function automatic fpsw_pkg::freq_t stretch_freq(int unsigned b, int unsigned d);
    int unsigned f;
    f = ClockHz / (b + 1) + 1 + d;
    if (f > FreqHi) f = FreqHi;
    return fpsw_pkg::freq_t'(f);
  endfunction

  task automatic send_tick(input logic adv);
    while (!quiet_window() && $urandom_range(0, 99) < 7) begin
      tick_if.valid <= 1'b0;
      @(negedge clk);
    end
    tick_if.valid   <= 1'b1;
    tick_if.advance <= adv;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain every pending result before the register write
  task automatic write_freq(input fpsw_pkg::freq_t f);
    tick_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_if.valid    <= 1'b1;
    cfg_if.out_freq <= f;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    #(20 * 400000);
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    hold_done    = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_done <= 1'b1;
      end else begin
        res_if.ready <= quiet_window() || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    int unsigned     sent;
    int unsigned     phase;
    int unsigned     n;
    int unsigned     sel;
    fpsw_pkg::freq_t f;

    rst_n           = 1'b0;
    hold_req        = 1'b0;
    tick_if.valid   = 1'b0;
    tick_if.advance = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.out_freq = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stopped after reset
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    // stop while already stopped
    write_freq('0);
    send_tick(1'b1);
    send_tick(1'b1);
    // highest frequency
    write_freq(fpsw_pkg::freq_t'(FreqHi));
    for (int k = 0; k < 6; k++) send_tick(k != 2);
    // lowest frequency: wave stays high for a very long time
    write_freq(fpsw_pkg::freq_t'(1));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    // stretched periods appear after three base periods
    write_freq(stretch_freq(2, 0));
    for (int k = 0; k < 10; k++) send_tick(1'b1);

    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) f = stretch_freq($urandom_range(2, 10), $urandom_range(0, 1));
      else if (sel < 82) f = fpsw_pkg::freq_t'($urandom_range(1000000, FreqHi));
      else if (sel < 90) f = fpsw_pkg::freq_t'($urandom_range(1, FreqHi));
      else if (sel < 96) f = '0;
      else f = $urandom_range(0, 1) ? fpsw_pkg::freq_t'(1) : fpsw_pkg::freq_t'(FreqHi);
      write_freq(f);
      n = $urandom_range(40, 220);
      if (phase == 3) begin
        // keep offering beats while the result side holds off
        n = 240;
        hold_req <= 1'b1;
      end
      for (int k = 0; k < n; k++) send_tick($urandom_range(0, 99) < 88);
      sent += n;
      phase++;
    end

    tick_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fpsw_pkg.sv
hw/rtl/fpsw_if.sv
hw/rtl/fractional_period_square_wave_top.sv
dv/fpsw_wave_checker.sv
dv/tb_fractional_period_square_wave_top.sv
